@@ hdl/weighted_image_chi_square_macros.svh @@
// Assertion macros shared by the chi-square block.
// No dependencies.
`ifndef WEIGHTED_IMAGE_CHI_SQUARE_MACROS_SVH
`define WEIGHTED_IMAGE_CHI_SQUARE_MACROS_SVH
`ifndef ASSERT_OFF
`define WICS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WICS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WICS_ASSERT(label, clk, rst_n, prop, msg)
`define WICS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hdl/wics_pkg.sv @@
// Shared types and constants of the weighted chi-square block.
// No dependencies.
package wics_pkg;
    localparam int ACC_BITS = 48;
    localparam int WEIGHT_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE = 3'd0;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 24'd65536;

    typedef enum logic [1:0] {
        t_IDLE = 2'd0,
        t_SUM  = 2'd1,
        t_DIV  = 2'd2,
        t_OUT  = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        t_D_IDLE = 2'd0,
        t_D_SQ   = 2'd1,
        t_D_RUN  = 2'd2,
        t_D_DONE = 2'd3
    } t_div_state;

    // Status of the divider toward the control.
    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } t_div_status;
endpackage

@@ hdl/wics_lane.sv @@
// One component lane: registered product of weight and pixel, masked when inactive.
// Uses wics_pkg.
module wics_lane
    import wics_pkg::*;
#(
    parameter int PIXEL_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic                                 i_active,
    input  logic [WEIGHT_BITS-1:0]               i_weight,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    output logic signed [PIXEL_BITS+WEIGHT_BITS:0] o_product
);
    logic signed [PIXEL_BITS+WEIGHT_BITS:0] r_product;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_active) begin
                r_product <= $signed({1'b0, i_weight}) * i_pixel;
            end else begin
                r_product <= '0;
            end
        end
    end

    assign o_product = r_product;
endmodule

@@ hdl/wics_div.sv @@
// Restoring divider: floor(a*a/d) with 48-bit saturation, one quotient bit a cycle.
// Uses wics_pkg and the macro header.
`include "weighted_image_chi_square_macros.svh"
module wics_div
    import wics_pkg::*;
#(
    parameter int NB = 64,
    parameter int DB = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NB-1:0]     i_mag,
    input  logic [DB-1:0]     i_den,
    output t_div_status       o_status,
    output logic [ACC_BITS-1:0] o_quot
);
    localparam int SQ = 2 * NB;
    localparam int CB = $clog2(SQ + 1);
    localparam int HB = (NB + 1) / 2;
    localparam logic [1:0] PH_LAST = 2'd2;

    t_div_state r_st, n_st;
    logic [NB-1:0] r_a;
    logic [SQ-1:0] r_num;
    logic [DB:0] r_rem;
    logic [DB-1:0] r_den;
    logic [ACC_BITS-1:0] r_q;
    logic r_sat;
    logic [CB-1:0] r_cnt;
    logic [1:0] r_ph;
    logic [DB:0] w_shift;
    logic w_ge;
    logic [HB-1:0] w_lo, w_hi;
    logic [HB-1:0] w_ma, w_mb;
    logic [2*HB-1:0] w_pp;
    logic [SQ-1:0] w_pp_sh;

    assign w_shift = {r_rem[DB-1:0], r_num[SQ-1]};
    assign w_ge = w_shift >= {1'b0, r_den};

    // The square is built from three half-width partial products, one a cycle:
    // low times low, twice high times low, then high times high.
    assign w_lo = r_a[HB-1:0];
    assign w_hi = HB'(r_a >> HB);
    assign w_pp = w_ma * w_mb;

    always_comb begin
        case (r_ph)
            2'd0: begin
                w_ma = w_lo;
                w_mb = w_lo;
                w_pp_sh = SQ'(w_pp);
            end
            2'd1: begin
                w_ma = w_hi;
                w_mb = w_lo;
                w_pp_sh = SQ'(w_pp) << (HB + 1);
            end
            default: begin
                w_ma = w_hi;
                w_mb = w_hi;
                w_pp_sh = SQ'(w_pp) << (2 * HB);
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_D_IDLE: if (i_start) n_st = t_D_SQ;
            t_D_SQ:   if (r_ph == PH_LAST) n_st = t_D_RUN;
            t_D_RUN:  if (r_cnt == CB'(1)) n_st = t_D_DONE;
            t_D_DONE: n_st = t_D_IDLE;
            default:  n_st = t_D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_D_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            t_D_IDLE: begin
                r_a <= i_mag;
                r_den <= i_den;
                r_num <= '0;
                r_ph <= '0;
            end
            t_D_SQ: begin
                r_num <= r_num + w_pp_sh;
                r_ph <= r_ph + 2'd1;
                r_rem <= '0;
                r_q <= '0;
                r_sat <= 1'b0;
                r_cnt <= CB'(SQ);
            end
            t_D_RUN: begin
                r_num <= {r_num[SQ-2:0], 1'b0};
                r_cnt <= r_cnt - CB'(1);
                if (w_ge) begin
                    r_rem <= w_shift - {1'b0, r_den};
                    if (r_q[ACC_BITS-1]) r_sat <= 1'b1;
                end else begin
                    r_rem <= w_shift;
                    if (r_q[ACC_BITS-1]) r_sat <= 1'b1;
                end
                r_q <= {r_q[ACC_BITS-2:0], w_ge};
            end
            default: ;
        endcase
    end

    assign o_status.busy = (r_st != t_D_IDLE);
    assign o_status.done = (r_st == t_D_DONE);
    assign o_status.sat = r_sat;
    assign o_quot = r_sat ? ACC_MAX : r_q;

    `WICS_ASSERT(a_done_after_run, i_clk, i_rst_n, o_status.done |-> $past(r_st == t_D_RUN), "done without run")
    `WICS_ASSERT(a_no_start_busy, i_clk, i_rst_n, (r_st == t_D_SQ && r_ph == 2'd0) |-> $past(r_st == t_D_IDLE), "bad start")
    `WICS_ASSERT(a_cnt_nonzero, i_clk, i_rst_n, (r_st == t_D_RUN) |-> (r_cnt != '0), "counter ran out")
endmodule

@@ hdl/weighted_image_chi_square.sv @@
// Top level of the weighted chi-square block: lanes, merge, divider, accumulator.
// Uses wics_pkg, wics_lane, wics_div and the macro header.
//
// Usage: one pixel beat on the input channel (i_valid/o_ready) carries a
// reference value and NUM_COMPONENTS component values. Masked pixels (reference
// zero) skip the divider. An unmasked pixel goes through the registered weight
// lanes, the combinational merge and a divider that squares the numerator on
// one half-width multiplier, then computes (r-t)^2/(|r|+t) one quotient bit a
// cycle over 2*(PIXEL_BITS+WEIGHT_BITS+5) bits; the next beat is taken only
// once the divider is through, so the divider loop sets the rate. On a beat
// with i_last_pixel set, one result beat (o_valid/i_ready) carries the sum and
// flags and the accumulator clears. The result sits in an output register;
// while the receiver stalls, the next pixel is still taken and worked on, but
// a second result waits until the first is taken.
// Reset (synchronous, active low) clears the accumulator, the flags, and sets
// all weights to 1.0 and the active count to NUM_COMPONENTS' max of four.
// Configuration writes go through i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// make them only while idle, as the block does not enforce this.
`include "weighted_image_chi_square_macros.svh"
module weighted_image_chi_square
    import wics_pkg::*;
#(
    parameter int NUM_COMPONENTS = 4,
    parameter int PIXEL_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [WEIGHT_BITS-1:0]       i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [PIXEL_BITS-1:0] i_ref_pixel,
    input  logic signed [PIXEL_BITS-1:0] i_comp_0,
    input  logic signed [PIXEL_BITS-1:0] i_comp_1,
    input  logic signed [PIXEL_BITS-1:0] i_comp_2,
    input  logic signed [PIXEL_BITS-1:0] i_comp_3,
    input  logic                         i_last_pixel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ACC_BITS-1:0]          o_chi_square,
    output logic                         o_saturated,
    output logic                         o_bad_variance
);
    localparam int NL = (NUM_COMPONENTS < 4) ? NUM_COMPONENTS : 4;
    localparam int PB = PIXEL_BITS + WEIGHT_BITS + 1;
    localparam int TB = PB + 3;
    localparam int MB = TB + 1;
    localparam int CNTB = $clog2(NUM_COMPONENTS + 1) + 3;

    t_state r_state, n_state;
    logic [2:0] r_active;
    logic [WEIGHT_BITS-1:0] r_weight [NL];
    logic signed [PIXEL_BITS-1:0] w_comp [4];
    logic signed [PIXEL_BITS-1:0] r_ref;
    logic r_last;
    logic signed [PB-1:0] w_prod [NL];
    logic signed [TB-1:0] w_t;
    logic signed [MB-1:0] r_n, r_d;
    logic [MB-1:0] w_mag;
    logic [MB-1:0] w_den;
    logic r_div_start;
    t_div_status w_div;
    logic [ACC_BITS-1:0] w_quot;
    logic [ACC_BITS-1:0] r_acc;
    logic r_sat_seen, r_var_seen;
    logic [ACC_BITS:0] w_sum;
    logic r_emit;
    logic w_take;
    logic [CNTB-1:0] w_cnt;
    logic signed [MB-1:0] w_rq;

    assign w_comp[0] = i_comp_0;
    assign w_comp[1] = i_comp_1;
    assign w_comp[2] = i_comp_2;
    assign w_comp[3] = i_comp_3;
    assign w_cnt = CNTB'(r_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 3'd4;
            for (int k = 0; k < NL; k++) r_weight[k] <= WEIGHT_ONE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ACTIVE) begin
                r_active <= i_cfg_data[2:0];
            end else begin
                for (int k = 0; k < NL; k++) begin
                    if (i_cfg_idx == CFG_IDX_BITS'(k + 1)) r_weight[k] <= i_cfg_data;
                end
            end
        end
    end

    assign w_take = i_valid && o_ready;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        wics_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
            .i_clk(i_clk),
            .i_load(w_take),
            .i_active(w_cnt > CNTB'(g)),
            .i_weight(r_weight[g]),
            .i_pixel(w_comp[g]),
            .o_product(w_prod[g])
        );
    end

    // Merge stage: add the lane products.
    always_comb begin
        w_t = '0;
        for (int k = 0; k < NL; k++) w_t = w_t + TB'(w_prod[k]);
    end

    assign w_rq = MB'(r_ref) <<< 16;
    assign w_mag = r_n[MB-1] ? MB'(-r_n) : MB'(r_n);
    assign w_den = MB'(r_d);

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_IDLE: if (w_take) n_state = t_SUM;
            t_SUM: begin
                if (r_ref != '0) n_state = t_DIV;
                else n_state = t_OUT;
            end
            t_DIV: if (w_div.done) n_state = t_OUT;
            t_OUT: if (!r_last || !o_valid || i_ready) n_state = t_IDLE;
            default: n_state = t_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == t_IDLE);
    end

    assign w_sum = {1'b0, r_acc} + {1'b0, w_quot};

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ref <= i_ref_pixel;
            r_last <= i_last_pixel;
        end
        if (r_state == t_SUM) begin
            r_n <= w_rq - MB'(w_t);
            r_d <= (r_ref[PIXEL_BITS-1] ? -w_rq : w_rq) + MB'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_acc <= '0;
            r_sat_seen <= 1'b0;
            r_var_seen <= 1'b0;
            r_div_start <= 1'b0;
            r_emit <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div_start <= (r_state == t_SUM) && (r_ref != '0);
            if (r_state == t_DIV && r_div_start) begin
                if (r_d <= 0) r_var_seen <= 1'b1;
            end
            if (r_state == t_DIV && w_div.done && r_d > 0) begin
                if (w_sum[ACC_BITS] || w_div.sat) r_sat_seen <= 1'b1;
                r_acc <= w_sum[ACC_BITS] ? ACC_MAX : w_sum[ACC_BITS-1:0];
            end
            if (r_state == t_OUT && n_state == t_IDLE && r_last) begin
                o_valid <= 1'b1;
                o_chi_square <= r_acc;
                o_saturated <= r_sat_seen;
                o_bad_variance <= r_var_seen;
                r_acc <= '0;
                r_sat_seen <= 1'b0;
                r_var_seen <= 1'b0;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            r_emit <= (r_state == t_OUT && n_state == t_IDLE && r_last);
        end
    end

    wics_div #(.NB(MB), .DB(MB)) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_mag(w_mag),
        .i_den(w_den),
        .o_status(w_div),
        .o_quot(w_quot)
    );

    `WICS_ASSERT(a_emit_valid, i_clk, i_rst_n, r_emit |-> o_valid, "result not shown")
    `WICS_ASSERT(a_ready_idle, i_clk, i_rst_n, o_ready |-> !w_div.busy, "ready while dividing")
    `WICS_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(o_chi_square), "result changed")
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for weighted_image_chi_square: drives pixel beats,
// predicts each per-image chi-square, and checks every result beat.
// Depends on wics_pkg and the weighted_image_chi_square RTL.
module tb;
    import wics_pkg::*;

    localparam int PIX = 24;
    localparam int NCOMP = 4;
    localparam int DRAIN_CYCLES = 300;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [CFG_IDX_BITS-1:0] REG_W0 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_W1 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_W2 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_W3 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE0 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE1 = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE2 = 3'd7;
    localparam logic signed [PIX-1:0] PIX_MAX = 24'sh7FFFFF;
    localparam logic signed [PIX-1:0] PIX_MIN = 24'sh800000;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 24'hFFFFFF;

    typedef struct {
        logic [ACC_BITS-1:0] chi;
        logic                sat;
        logic                bad_var;
    } image_sum_t;

    typedef struct {
        logic signed [PIX-1:0] rf;
        logic signed [PIX-1:0] c0, c1, c2, c3;
        logic                  last;
        logic                  typed;
        image_sum_t            sum;
    } pixel_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [WEIGHT_BITS-1:0]  i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [PIX-1:0]   i_ref_pixel;
    logic signed [PIX-1:0]   i_comp_0, i_comp_1, i_comp_2, i_comp_3;
    logic                    i_last_pixel;
    logic                    o_valid;
    logic                    i_ready;
    logic [ACC_BITS-1:0]     o_chi_square;
    logic                    o_saturated;
    logic                    o_bad_variance;

    // Typed expectation that travels with the beat currently offered.
    logic       beat_typed;
    image_sum_t beat_sum;

    // Predictor copy of the configuration and running state.
    logic [2:0]             model_active;
    logic [WEIGHT_BITS-1:0] model_weight[NCOMP];
    logic [ACC_BITS-1:0]    model_acc;
    logic                   model_sat;
    logic                   model_bad;

    image_sum_t image_sum_q[$];
    int  err_count;
    int  idle_cycles;
    bit  quiet;
    bit  hold_req;

    weighted_image_chi_square uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Adds one pixel to the predicted chi-square of the current image.
    task automatic absorb_pixel(input logic signed [PIX-1:0] rf,
                                input logic signed [PIX-1:0] comps[NCOMP]);
        logic signed [63:0] r, t, rq, d, n, w64, c64;
        logic [63:0]  mag;
        logic [127:0] q;
        logic [ACC_BITS:0] acc_wide;
        int cnt;
        r = rf;
        if (r == 0) return;
        cnt = (model_active > NCOMP) ? NCOMP : model_active;
        t = 0;
        for (int i = 0; i < cnt; i++) begin
            w64 = {40'b0, model_weight[i]};
            c64 = comps[i];
            t = t + w64 * c64;
        end
        rq = r * 64'sd65536;
        d = ((r < 0) ? -rq : rq) + t;
        if (d <= 0) begin
            model_bad = 1'b1;
            return;
        end
        n = rq - t;
        mag = (n < 0) ? -n : n;
        q = ({64'b0, mag} * {64'b0, mag}) / {64'b0, d};
        if (q > {80'b0, ACC_MAX}) begin
            q = {80'b0, ACC_MAX};
            model_sat = 1'b1;
        end
        acc_wide = {1'b0, model_acc} + {1'b0, q[ACC_BITS-1:0]};
        if (acc_wide[ACC_BITS]) begin
            model_acc = ACC_MAX;
            model_sat = 1'b1;
        end else begin
            model_acc = acc_wide[ACC_BITS-1:0];
        end
    endtask

    // Input side: configuration writes and accepted pixel beats feed the predictor.
    always @(posedge i_clk) begin
        logic signed [PIX-1:0] comps[NCOMP];
        image_sum_t s;
        if (!i_rst_n) begin
            model_active = 3'd4;
            for (int i = 0; i < NCOMP; i++) model_weight[i] = WEIGHT_ONE;
            model_acc = '0;
            model_sat = 1'b0;
            model_bad = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ACTIVE) model_active = i_cfg_data[2:0];
                else if (i_cfg_idx <= REG_W3) model_weight[i_cfg_idx - 1] = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                comps[0] = i_comp_0;
                comps[1] = i_comp_1;
                comps[2] = i_comp_2;
                comps[3] = i_comp_3;
                absorb_pixel(i_ref_pixel, comps);
                if (i_last_pixel) begin
                    s.chi = model_acc;
                    s.sat = model_sat;
                    s.bad_var = model_bad;
                    image_sum_q.push_back(beat_typed ? beat_sum : s);
                    model_acc = '0;
                    model_sat = 1'b0;
                    model_bad = 1'b0;
                end
            end
        end
    end

    // Result side.
    always @(posedge i_clk) begin
        image_sum_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (image_sum_q.size() == 0) begin
                $display("MISMATCH unexpected result beat at %0t", $time);
                err_count++;
            end else begin
                want = image_sum_q.pop_front();
                if (o_chi_square !== want.chi)
                    report_mismatch("chi_square", o_chi_square, want.chi);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
                if (o_bad_variance !== want.bad_var)
                    report_mismatch("bad_variance", o_bad_variance, want.bad_var);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, mostly short, plus one long hold-off on request.
    initial begin
        int k;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else begin
                k = $urandom_range(0, 99);
                if (k < 3) begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end else begin
                    i_ready <= (k >= 30);
                end
            end
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 60) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(input pixel_row_t row);
        int gap;
        i_valid <= 1'b1;
        i_ref_pixel <= row.rf;
        i_comp_0 <= row.c0;
        i_comp_1 <= row.c1;
        i_comp_2 <= row.c2;
        i_comp_3 <= row.c3;
        i_last_pixel <= row.last;
        beat_typed <= row.typed;
        beat_sum <= row.sum;
        do @(posedge i_clk); while (!o_ready);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [WEIGHT_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every image result is back and the divider has settled.
    task automatic drain();
        i_valid <= 1'b0;
        while (image_sum_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic pixel_row_t mk_row(input logic signed [PIX-1:0] rf,
                                          input logic signed [PIX-1:0] c0, c1, c2, c3,
                                          input logic last, input logic typed,
                                          input logic [ACC_BITS-1:0] chi,
                                          input logic sat, input logic bad_var);
        pixel_row_t row;
        row.rf = rf;
        row.c0 = c0;
        row.c1 = c1;
        row.c2 = c2;
        row.c3 = c3;
        row.last = last;
        row.typed = typed;
        row.sum.chi = chi;
        row.sum.sat = sat;
        row.sum.bad_var = bad_var;
        return row;
    endfunction

    function automatic logic signed [PIX-1:0] rand_pixel();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return PIX'($urandom());
        if (k < 75) return PIX'($urandom_range(0, 600) - 300);
        if (k < 85) return (k[0]) ? PIX_MAX : PIX_MIN;
        return PIX'($urandom_range(0, 65535) - 32768);
    endfunction

    function automatic pixel_row_t rand_row(input int last_odds);
        logic signed [PIX-1:0] rf;
        rf = ($urandom_range(0, 9) == 0) ? '0 : rand_pixel();
        return mk_row(rf, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(),
                      $urandom_range(1, last_odds) == 1, 1'b0, '0, 1'b0, 1'b0);
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) return WEIGHT_BITS'($urandom_range(0, 255));
        if (k < 4) return WEIGHT_ONE;
        if (k == 4) return WEIGHT_MAX;
        if (k == 5) return '0;
        return WEIGHT_BITS'($urandom());
    endfunction

    pixel_row_t directed_rows[$];

    initial begin
        pixel_row_t row;
        err_count = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ref_pixel = '0;
        i_comp_0 = '0;
        i_comp_1 = '0;
        i_comp_2 = '0;
        i_comp_3 = '0;
        i_last_pixel = 1'b0;
        beat_typed = 1'b0;
        beat_sum = '{default: '0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults after reset: four components, all weights 1.0.
        directed_rows.push_back(mk_row(0, PIX_MAX, PIX_MIN, 5, -5, 1, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(1, 0, 0, 0, 0, 1, 1, 48'd65536, 0, 0));
        directed_rows.push_back(mk_row(-1, 0, 0, 0, 0, 1, 1, 48'd65536, 0, 0));
        directed_rows.push_back(mk_row(1, -2, 0, 0, 0, 1, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(PIX_MAX, -24'sd8388606, 0, 0, 0, 1, 1,
                                       ACC_MAX, 1, 0));
        directed_rows.push_back(mk_row(PIX_MIN, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                                       0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(PIX_MAX, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
                                       0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 1, 2, 3, 4, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN,
                                       1, 0, 0, 0, 0));
        // Several saturating terms in a row push the accumulator past its top.
        for (int i = 0; i < 3; i++)
            directed_rows.push_back(mk_row(PIX_MAX, -24'sd8388606, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(-24'sd4000000, 24'sd4000000, -24'sd3, 24'sd7, 0,
                                       1, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(24'sd1000, 24'sd200, 24'sd300, 24'sd100, 24'sd399,
                                       1, 0, 0, 0, 0));
        foreach (directed_rows[i]) send_pixel(directed_rows[i]);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_ACTIVE, 24'd1);
                    write_reg(REG_W0, WEIGHT_MAX);
                end
                1: begin
                    write_reg(REG_ACTIVE, 24'd0);
                    write_reg(REG_W1, '0);
                end
                2: begin
                    write_reg(REG_ACTIVE, 24'd7);
                    write_reg(REG_W2, WEIGHT_MAX);
                    write_reg(REG_W3, 24'd1);
                end
                3: begin
                    write_reg(REG_ACTIVE, 24'd2);
                    write_reg(REG_W0, '0);
                    write_reg(REG_W1, WEIGHT_ONE);
                end
                4: begin
                    // Writes to unused indexes must leave the weights alone.
                    write_reg(REG_SPARE0, WEIGHT_MAX);
                    write_reg(REG_SPARE1, 24'h5A5A5A);
                    write_reg(REG_SPARE2, 24'hA5A5A5);
                    write_reg(REG_ACTIVE, 24'hFFFFFC);
                end
                default: begin
                    write_reg(REG_ACTIVE, WEIGHT_BITS'($urandom_range(0, 7)));
                    write_reg(REG_W0, rand_weight());
                    write_reg(REG_W1, rand_weight());
                    write_reg(REG_W2, rand_weight());
                    write_reg(REG_W3, rand_weight());
                end
            endcase
            quiet = (phase == 6 || phase == 9);
            if (phase == 7) hold_req = 1'b1;
            for (int n = 0; n < 90; n++) begin
                row = rand_row((phase == 7) ? 2 : 12);
                send_pixel(row);
            end
            row = rand_row(1);
            send_pixel(row);
            drain();
        end
        quiet = 1'b0;

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
